// File: sv/sha_pkg.sv
// Shared types and constants for the SHA-256 hash engine.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] vars_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROUND,
      S_FINAL,
      S_PAD,
      S_LEN,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_DATA,
      PH_PAD,
      PH_LEN
   } phase_type;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_INDEX = 3'd7;

   localparam word_type INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage
`default_nettype wire

// File: sv/sha_round.sv
// One SHA-256 compression round with the message schedule step.
`timescale 1ns / 1ps
`default_nettype none
module sha_round
   import sha_pkg::*;
(
   input  vars_type v,
   input  word_type k,
   input  logic     sched,
   input  word_type w0,
   input  word_type w1,
   input  word_type w9,
   input  word_type w14,
   output vars_type v_next,
   output word_type w_cur
);

   word_type s0w;
   word_type s1w;
   word_type big_s0;
   word_type big_s1;
   word_type ch;
   word_type mj;
   word_type t1;
   word_type t2;

   always_comb begin
      s0w = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
      s1w = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
      w_cur = sched ? (w0 + s0w + w9 + s1w) : w0;

      big_s1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]}
             ^ {v[4][24:0], v[4][31:25]};
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + big_s1 + ch + k + w_cur;

      big_s0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]}
             ^ {v[0][21:0], v[0][31:22]};
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = big_s0 + mj;

      v_next[0] = t1 + t2;
      v_next[1] = v[0];
      v_next[2] = v[1];
      v_next[3] = v[2];
      v_next[4] = v[3] + t1;
      v_next[5] = v[4];
      v_next[6] = v[5];
      v_next[7] = v[6];
   end

endmodule
`default_nettype wire

// File: sv/sha256_hash_engine.sv
// SHA-256 hash engine: byte stream in, eight digest words out.
// Usage:
//   req channel: one word per handshake, a message byte with byte_present and
//   last_item flags. byte_present 0 with last_item 1 closes an empty tail.
//   rsp channel: after a last item, eight digest words, index 0 first,
//   last_word set on index 7. The engine then returns to the initial hash.
// Timing:
//   A byte that does not complete a block and is not a last item is taken and the engine stays idle.
//   A byte that completes a 64-byte block starts the compression: 64 rounds
//   at one per cycle through the single round unit, then a fold step into
//   the hash (S_FINAL), after which req_ready returns.
//   A last item adds a padding step (S_PAD), an optional extra block
//   when 56 or more bytes sit in the buffer, a length step (S_LEN), the
//   compression, then eight digest words, one per cycle if rsp_ready is high.
//   req_ready is high only while idle.
// Reset: synchronous, active high; loads the initial hash, clears the count.
// Stall: a digest word is held in its register until rsp_ready takes it;
//   nothing else moves meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module sha256_hash_engine
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic        last_pend_ff, last_pend_in;
   logic [5:0]  round_ff, round_in;
   logic [60:0] count_ff, count_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   vars_type    hash_ff, hash_in;
   vars_type    v_ff, v_in;
   word_type    win_ff [16];
   word_type    win_in [16];

   logic        req_accept;
   logic        rsp_accept;
   logic        start_rounds;
   logic [60:0] count_inc;
   logic [5:0]  pos;
   logic [63:0] len_bits;
   vars_type    v_next;
   word_type    w_cur;

   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid && rsp_ready;
   assign count_inc  = count_ff + 61'd1;
   assign pos        = count_ff[5:0];
   assign len_bits   = {count_ff, 3'b000};

   sha_round u_round (
      .v      (v_ff),
      .k      (ROUND_K[round_ff]),
      .sched  (round_ff[5:4] != 2'b00),
      .w0     (win_ff[0]),
      .w1     (win_ff[1]),
      .w9     (win_ff[9]),
      .w14    (win_ff[14]),
      .v_next (v_next),
      .w_cur  (w_cur)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_byte_present && (count_inc[5:0] == 6'd0)) begin
                  state_in = S_ROUND;
               end else if (req_last_item) begin
                  state_in = S_PAD;
               end
            end
         end
         S_ROUND: begin
            if (round_ff == LAST_ROUND) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            case (phase_ff)
               PH_DATA: state_in = last_pend_ff ? S_PAD : S_IDLE;
               PH_PAD:  state_in = S_LEN;
               PH_LEN:  state_in = S_OUT;
               default: state_in = S_IDLE;
            endcase
         end
         S_PAD: state_in = (pos >= LEN_POS) ? S_ROUND : S_LEN;
         S_LEN: state_in = S_ROUND;
         S_OUT: begin
            if (rsp_ready && (out_idx_ff == LAST_INDEX)) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      start_rounds = 1'b0;
      phase_in     = phase_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_byte_present && (count_inc[5:0] == 6'd0)) begin
               start_rounds = 1'b1;
               phase_in     = PH_DATA;
            end
         end
         S_PAD: begin
            if (pos >= LEN_POS) begin
               start_rounds = 1'b1;
               phase_in     = PH_PAD;
            end
         end
         S_LEN: begin
            start_rounds = 1'b1;
            phase_in     = PH_LEN;
         end
         S_OUT:   rsp_valid = 1'b1;
         default: ;
      endcase
   end

   // schedule window / block buffer
   always_comb begin
      logic [5:0] bpos;
      bpos = '0;
      win_in = win_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_byte_present) begin
               for (int j = 0; j < 4; j++) begin
                  if (2'(j) == count_ff[1:0]) begin
                     win_in[count_ff[5:2]][31 - 8 * j -: 8] = req_data_byte;
                  end
               end
            end
         end
         S_PAD: begin
            for (int i = 0; i < 16; i++) begin
               for (int j = 0; j < 4; j++) begin
                  bpos = {4'(i), 2'(j)};
                  if (bpos == pos) begin
                     win_in[i][31 - 8 * j -: 8] = PAD_BYTE;
                  end else if (bpos > pos) begin
                     win_in[i][31 - 8 * j -: 8] = 8'h00;
                  end
               end
            end
         end
         S_LEN: begin
            if (phase_ff == PH_PAD) begin
               for (int i = 0; i < 14; i++) begin
                  win_in[i] = '0;
               end
            end
            win_in[14] = len_bits[63:32];
            win_in[15] = len_bits[31:0];
         end
         S_ROUND: begin
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[15] = w_cur;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      last_pend_in = last_pend_ff;
      count_in     = count_ff;
      out_idx_in   = out_idx_ff;
      hash_in      = hash_ff;
      round_in     = (state_ff == S_ROUND) ? round_ff + 6'd1 : 6'd0;

      if (start_rounds) begin
         v_in = hash_ff;
      end else if (state_ff == S_ROUND) begin
         v_in = v_next;
      end else begin
         v_in = v_ff;
      end

      if (req_accept) begin
         last_pend_in = req_last_item;
         if (req_byte_present) begin
            count_in = count_inc;
         end
      end

      if (state_ff == S_FINAL) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + v_ff[i];
         end
      end

      if (rsp_accept) begin
         out_idx_in = out_idx_ff + 3'd1;
         for (int i = 0; i < 7; i++) begin
            hash_in[i] = hash_ff[i + 1];
         end
         hash_in[7] = INIT_H[out_idx_ff];
         if (out_idx_ff == LAST_INDEX) begin
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_DATA;
         last_pend_ff <= 1'b0;
         round_ff     <= '0;
         count_ff     <= '0;
         out_idx_ff   <= '0;
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= INIT_H[i];
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         last_pend_ff <= last_pend_in;
         round_ff     <= round_in;
         count_ff     <= count_in;
         out_idx_ff   <= out_idx_in;
         hash_ff      <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      win_ff <= win_in;
   end

   assign rsp_digest_word = hash_ff[0];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == LAST_INDEX);

endmodule
`default_nettype wire

// File: sv/sha_checker.sv
// Port-level checks for the SHA-256 hash engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sha_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        req_last_item,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [2:0]  rsp_word_index,
   input wire        rsp_last_word
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req_ready high while digest pending");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last_word does not match word_index");

   a_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=> rsp_valid)
      else $error("digest burst broken");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word)
      |=> (rsp_word_index == 3'($past(rsp_word_index) + 3'd1)))
      else $error("word_index did not advance");

   a_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_last_item) |=> !rsp_valid)
      else $error("digest without last item");

endmodule

bind sha256_hash_engine sha_checker u_sha_checker (.*);
`default_nettype wire
